>>> rtl/ursz_pkg.sv
// Package for the ultrasonic range, speed and zone block.
// Holds the widths, reset values, register map, sequencer types and config bundle.
// No dependencies.
package ursz_pkg;

  // Default widths of the counters that the top level takes as parameters
  localparam int ECHO_WIDTH_BITS_DEF = 16;
  localparam int MS_COUNT_BITS_DEF   = 24;

  // Fixed widths and constants
  localparam int TICKS_PER_MS = 1000;
  localparam int SPEED_SCALE  = 1000;
  localparam int DIST_W       = 16;
  localparam int SCALE_W      = 10;
  localparam int TIMER_W      = 20;
  localparam int US_W         = 10;
  localparam int MS_CFG_W     = 10;
  localparam int DIVISOR_W    = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;

  // Register reset values
  localparam logic [DIVISOR_W-1:0] CM_DIVISOR_RST    = 8'd58;
  localparam logic [DIST_W-1:0]    NEAR_LIMIT_RST    = 16'd10;
  localparam logic [DIST_W-1:0]    MID_LIMIT_RST     = 16'd20;
  localparam logic [DIST_W-1:0]    FAR_LIMIT_RST     = 16'd40;
  localparam logic [MS_CFG_W-1:0]  SETTLE_MS_RST     = 10'd60;
  localparam logic [MS_CFG_W-1:0]  NEAR_PULSE_MS_RST = 10'd100;
  localparam logic [MS_CFG_W-1:0]  MID_PULSE_MS_RST  = 10'd150;
  localparam logic [MS_CFG_W-1:0]  FAR_PULSE_MS_RST  = 10'd200;

  // Phase lengths of the trigger sequence, in ticks
  localparam logic [TIMER_W-1:0] TRIG_LOW_TICKS  = 20'd2;
  localparam logic [TIMER_W-1:0] TRIG_HIGH_TICKS = 20'd10;
  localparam logic [TIMER_W-1:0] REPORT_TICKS    = 20'd1;

  // Register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_CM_DIVISOR    = 3'd0,
    REG_NEAR_LIMIT    = 3'd1,
    REG_MID_LIMIT     = 3'd2,
    REG_FAR_LIMIT     = 3'd3,
    REG_SETTLE_MS     = 3'd4,
    REG_NEAR_PULSE_MS = 3'd5,
    REG_MID_PULSE_MS  = 3'd6,
    REG_FAR_PULSE_MS  = 3'd7
  } reg_idx_t;

  // Measurement cycle phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LOW    = 3'd1,
    PH_HIGH   = 3'd2,
    PH_SETTLE = 3'd3,
    PH_PULSE  = 3'd4,
    PH_REPORT = 3'd5
  } phase_t;

  // Selected zone
  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_NEAR = 2'd1,
    ZONE_MID  = 2'd2,
    ZONE_FAR  = 2'd3
  } zone_t;

  // Per-tick control sequencer
  typedef enum logic [2:0] {
    C_IDLE  = 3'd0,
    C_ECHO  = 3'd1,
    C_SEQ   = 3'd2,
    C_SPDIV = 3'd3,
    C_FIN   = 3'd4,
    C_DONE  = 3'd5
  } ctl_t;

  // Configuration bundle
  typedef struct packed {
    logic [DIVISOR_W-1:0] cm_divisor;
    logic [DIST_W-1:0]    near_limit_cm;
    logic [DIST_W-1:0]    mid_limit_cm;
    logic [DIST_W-1:0]    far_limit_cm;
    logic [MS_CFG_W-1:0]  settle_ms;
    logic [MS_CFG_W-1:0]  near_pulse_ms;
    logic [MS_CFG_W-1:0]  mid_pulse_ms;
    logic [MS_CFG_W-1:0]  far_pulse_ms;
  } cfg_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/ursz_cfg.sv
// Configuration registers behind an APB-style port.
// Depends on ursz_pkg for the register map, reset values and cfg_t.
module ursz_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ursz_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ursz_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ursz_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output ursz_pkg::cfg_t                cfg
);
  import ursz_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Decode a write request into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CM_DIVISOR:    cfg_nxt.cm_divisor    = cfg_pwdata[DIVISOR_W-1:0];
        REG_NEAR_LIMIT:    cfg_nxt.near_limit_cm = cfg_pwdata[DIST_W-1:0];
        REG_MID_LIMIT:     cfg_nxt.mid_limit_cm  = cfg_pwdata[DIST_W-1:0];
        REG_FAR_LIMIT:     cfg_nxt.far_limit_cm  = cfg_pwdata[DIST_W-1:0];
        REG_SETTLE_MS:     cfg_nxt.settle_ms     = cfg_pwdata[MS_CFG_W-1:0];
        REG_NEAR_PULSE_MS: cfg_nxt.near_pulse_ms = cfg_pwdata[MS_CFG_W-1:0];
        REG_MID_PULSE_MS:  cfg_nxt.mid_pulse_ms  = cfg_pwdata[MS_CFG_W-1:0];
        REG_FAR_PULSE_MS:  cfg_nxt.far_pulse_ms  = cfg_pwdata[MS_CFG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cm_divisor    <= CM_DIVISOR_RST;
      cfg_r.near_limit_cm <= NEAR_LIMIT_RST;
      cfg_r.mid_limit_cm  <= MID_LIMIT_RST;
      cfg_r.far_limit_cm  <= FAR_LIMIT_RST;
      cfg_r.settle_ms     <= SETTLE_MS_RST;
      cfg_r.near_pulse_ms <= NEAR_PULSE_MS_RST;
      cfg_r.mid_pulse_ms  <= MID_PULSE_MS_RST;
      cfg_r.far_pulse_ms  <= FAR_PULSE_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_CM_DIVISOR:    cfg_prdata = CFG_DW'(cfg_r.cm_divisor);
      REG_NEAR_LIMIT:    cfg_prdata = CFG_DW'(cfg_r.near_limit_cm);
      REG_MID_LIMIT:     cfg_prdata = CFG_DW'(cfg_r.mid_limit_cm);
      REG_FAR_LIMIT:     cfg_prdata = CFG_DW'(cfg_r.far_limit_cm);
      REG_SETTLE_MS:     cfg_prdata = CFG_DW'(cfg_r.settle_ms);
      REG_NEAR_PULSE_MS: cfg_prdata = CFG_DW'(cfg_r.near_pulse_ms);
      REG_MID_PULSE_MS:  cfg_prdata = CFG_DW'(cfg_r.mid_pulse_ms);
      REG_FAR_PULSE_MS:  cfg_prdata = CFG_DW'(cfg_r.far_pulse_ms);
    endcase
  end

endmodule

>>> rtl/ursz_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ursz_pkg for div_stat_t.
module ursz_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  output logic [DVD_W-1:0]     quotient,
  output ursz_pkg::div_stat_t  stat
);
  import ursz_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;

  // Shift in the next dividend bit and try the subtraction
  assign trial     = {rem_r, quo_r[DVD_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      if (!trial_sub[DVS_W]) begin
        rem_r <= trial_sub[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // Count the iterations and flag the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1)) && !start;
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

>>> rtl/ultrasonic_range_speed_zone.sv
// Ultrasonic ranging block with speed estimate and zone indicator pulse; top level.
// Depends on ursz_pkg, ursz_cfg (register port) and ursz_div (shared divider).
//
// Each input request is one microsecond tick (echo level and read request) and
// yields exactly one result request with the trigger, indicator, report and busy
// levels plus the latest distance and speed. After acceptance a tick steps through
// every phase that has run out, then waits for the output register to be free.
// A falling echo edge first runs the distance division, and the end of the settle
// wait runs the speed division, when time has passed since the last read, before
// the finishing step; both run on the one shared bit-serial divider, DVD_W being
// the larger of ECHO_WIDTH_BITS and 26.
// The input is not ready while a tick is in progress. A finished result waits in
// the output register, and the next tick is accepted meanwhile.
module ultrasonic_range_speed_zone #(
  parameter int ECHO_WIDTH_BITS = ursz_pkg::ECHO_WIDTH_BITS_DEF,
  parameter int MS_COUNT_BITS   = ursz_pkg::MS_COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, from bit 0: read_request, echo_level, zero fill
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ursz_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata, from bit 0: trigger_out, close_led, far_led, buzzer_out,
  // report_valid, distance_out[15:0], speed_out[15:0], busy_res, zero fill
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ursz_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ursz_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [ursz_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [ursz_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import ursz_pkg::*;

  localparam int PROD_W = DIST_W + SCALE_W;
  localparam int DVD_W  = (ECHO_WIDTH_BITS > PROD_W) ? ECHO_WIDTH_BITS : PROD_W;
  localparam int DVS_W  = (MS_COUNT_BITS > DIVISOR_W) ? MS_COUNT_BITS : DIVISOR_W;

  cfg_t      cfg;
  div_stat_t div_stat;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic [DVD_W-1:0]  div_quo;
  logic [DIST_W-1:0] quo_sat;

  ctl_t                     ctl_r, ctl_nxt;
  phase_t                   phase_r, phase_nxt;
  zone_t                    zone_r, zone_nxt;
  logic [TIMER_W-1:0]       timer_r, timer_nxt;
  logic                     echo_prev_r, echo_prev_nxt;
  logic [ECHO_WIDTH_BITS-1:0] echo_width_r, echo_width_nxt;
  logic [DIST_W-1:0]        dist_now_r, dist_now_nxt;
  logic [DIST_W-1:0]        dist_before_r, dist_before_nxt;
  logic [DIST_W-1:0]        speed_r, speed_nxt;
  logic [MS_COUNT_BITS-1:0] ms_r, ms_nxt;
  logic [US_W-1:0]          us_r, us_nxt;
  logic                     req_r, req_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  logic               accept;
  logic               in_req;
  logic               in_echo;
  logic               echo_fall;
  logic [US_W-1:0]    us_inc;
  logic [TIMER_W-1:0] phase_len;
  logic               phase_adv;
  phase_t             phase_eff;
  logic [DIST_W-1:0]  dist_diff;
  logic [PROD_W-1:0]  speed_prod;
  logic               out_free;
  logic               pulse_on;
  logic               o_trig, o_close, o_far, o_buzz, o_rep, o_busy;

  ursz_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ursz_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign in_tready = (ctl_r == C_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_req    = in_tdata[0];
  assign in_echo   = in_tdata[1];
  assign echo_fall = !in_echo && echo_prev_r && (echo_width_r != '0) &&
                     (cfg.cm_divisor != '0);
  assign us_inc    = us_r + US_W'(1);
  assign out_free  = !out_valid_r || out_tready;

  // Saturate the quotient to the distance and speed width
  assign quo_sat = (|div_quo[DVD_W-1:DIST_W]) ? '1 : div_quo[DIST_W-1:0];

  // Absolute distance change scaled to per-second
  assign dist_diff  = (dist_now_r >= dist_before_r) ? (dist_now_r - dist_before_r)
                                                     : (dist_before_r - dist_now_r);
  assign speed_prod = PROD_W'(dist_diff) * PROD_W'(SPEED_SCALE);

  // Length of the current phase in ticks
  always_comb begin
    phase_len = '0;
    unique case (phase_r)
      PH_IDLE:   phase_len = '0;
      PH_LOW:    phase_len = TRIG_LOW_TICKS;
      PH_HIGH:   phase_len = TRIG_HIGH_TICKS;
      PH_SETTLE: phase_len = TIMER_W'(cfg.settle_ms * TICKS_PER_MS);
      PH_PULSE: begin
        case (zone_r)
          ZONE_NEAR: phase_len = TIMER_W'(cfg.near_pulse_ms * TICKS_PER_MS);
          ZONE_MID:  phase_len = TIMER_W'(cfg.mid_pulse_ms * TICKS_PER_MS);
          ZONE_FAR:  phase_len = TIMER_W'(cfg.far_pulse_ms * TICKS_PER_MS);
          default:   phase_len = '0;
        endcase
      end
      PH_REPORT: phase_len = REPORT_TICKS;
      default:   phase_len = '0;
    endcase
  end

  assign phase_adv = (phase_r != PH_IDLE) && (timer_r >= phase_len);
  assign phase_eff = (phase_r == PH_IDLE && req_r) ? PH_LOW : phase_r;

  // Result levels follow the state left at the end of the tick
  assign pulse_on = (phase_r == PH_PULSE);
  assign o_trig   = (phase_r == PH_HIGH);
  assign o_close  = pulse_on && (zone_r == ZONE_NEAR || zone_r == ZONE_MID);
  assign o_far    = pulse_on && (zone_r == ZONE_FAR);
  assign o_buzz   = pulse_on && (zone_r == ZONE_NEAR);
  assign o_rep    = (phase_r == PH_REPORT);
  assign o_busy   = (phase_r != PH_IDLE);

  // Sequencer: next state, divider requests and state updates
  always_comb begin
    ctl_nxt         = ctl_r;
    phase_nxt       = phase_r;
    zone_nxt        = zone_r;
    timer_nxt       = timer_r;
    echo_prev_nxt   = echo_prev_r;
    echo_width_nxt  = echo_width_r;
    dist_now_nxt    = dist_now_r;
    dist_before_nxt = dist_before_r;
    speed_nxt       = speed_r;
    ms_nxt          = ms_r;
    us_nxt          = us_r;
    req_nxt         = req_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    div_start       = 1'b0;
    div_dvd         = DVD_W'(echo_width_r);
    div_dvs         = DVS_W'(cfg.cm_divisor);

    unique case (ctl_r)
      C_IDLE: begin
        if (accept) begin
          req_nxt       = in_req;
          echo_prev_nxt = in_echo;
          // Measure the echo high time, saturating
          if (in_echo) begin
            if (!echo_prev_r) begin
              echo_width_nxt = ECHO_WIDTH_BITS'(1);
            end else if (echo_width_r != '1) begin
              echo_width_nxt = echo_width_r + ECHO_WIDTH_BITS'(1);
            end
          end
          // Advance the millisecond count since the last read
          if (us_inc >= US_W'(TICKS_PER_MS)) begin
            us_nxt = '0;
            if (ms_r != '1) begin
              ms_nxt = ms_r + MS_COUNT_BITS'(1);
            end
          end else begin
            us_nxt = us_inc;
          end
          if (echo_fall) begin
            div_start = 1'b1;
            ctl_nxt   = C_ECHO;
          end else begin
            ctl_nxt = C_SEQ;
          end
        end
      end

      C_ECHO: begin
        if (div_stat.done) begin
          dist_now_nxt = quo_sat;
          ctl_nxt      = C_SEQ;
        end
      end

      C_SEQ: begin
        if (phase_adv) begin
          if (phase_r == PH_SETTLE) begin
            // Speed only when time has passed since the last read
            if (ms_r != '0) begin
              div_start = 1'b1;
              div_dvd   = DVD_W'(speed_prod);
              div_dvs   = DVS_W'(ms_r);
              ctl_nxt   = C_SPDIV;
            end else begin
              ctl_nxt = C_FIN;
            end
          end else begin
            timer_nxt = '0;
            unique case (phase_r)
              PH_LOW:    phase_nxt = PH_HIGH;
              PH_HIGH:   phase_nxt = PH_SETTLE;
              PH_PULSE:  phase_nxt = PH_REPORT;
              PH_REPORT: phase_nxt = PH_IDLE;
              default:   phase_nxt = PH_IDLE;
            endcase
          end
        end else begin
          phase_nxt = phase_eff;
          if (phase_eff != PH_IDLE) begin
            timer_nxt = timer_r + TIMER_W'(1);
          end
          ctl_nxt = C_DONE;
        end
      end

      C_SPDIV: begin
        if (div_stat.done) begin
          speed_nxt = quo_sat;
          ctl_nxt   = C_FIN;
        end
      end

      C_FIN: begin
        // Close the settle wait: restart the interval and pick the zone
        dist_before_nxt = dist_now_r;
        ms_nxt          = '0;
        us_nxt          = '0;
        if (dist_now_r <= cfg.near_limit_cm) begin
          zone_nxt = ZONE_NEAR;
        end else if (dist_now_r <= cfg.mid_limit_cm) begin
          zone_nxt = ZONE_MID;
        end else if (dist_now_r <= cfg.far_limit_cm) begin
          zone_nxt = ZONE_FAR;
        end else begin
          zone_nxt = ZONE_NONE;
        end
        phase_nxt = PH_PULSE;
        timer_nxt = '0;
        ctl_nxt   = C_SEQ;
      end

      C_DONE: begin
        // Hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDATA_W - 2 * DIST_W - 6){1'b0}}, o_busy, speed_r,
                           dist_now_r, o_rep, o_buzz, o_far, o_close, o_trig};
          ctl_nxt       = C_IDLE;
        end
      end

      default: ctl_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= C_IDLE;
      phase_r       <= PH_IDLE;
      zone_r        <= ZONE_NONE;
      timer_r       <= '0;
      echo_prev_r   <= 1'b0;
      echo_width_r  <= '0;
      dist_now_r    <= '0;
      dist_before_r <= '0;
      speed_r       <= '0;
      ms_r          <= '0;
      us_r          <= '0;
      req_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      ctl_r         <= ctl_nxt;
      phase_r       <= phase_nxt;
      zone_r        <= zone_nxt;
      timer_r       <= timer_nxt;
      echo_prev_r   <= echo_prev_nxt;
      echo_width_r  <= echo_width_nxt;
      dist_now_r    <= dist_now_nxt;
      dist_before_r <= dist_before_nxt;
      speed_r       <= speed_nxt;
      ms_r          <= ms_nxt;
      us_r          <= us_nxt;
      req_r         <= req_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Output payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // A tick in progress blocks the next request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after an accepted request");

  // The shared divider is never restarted mid-division
  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A report tick is always part of a busy cycle
  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[5 + 2 * DIST_W])
    else $error("report without busy");

  // Trigger, zone pulse and report never overlap
  a_levels_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({out_tdata[0], out_tdata[1] | out_tdata[2], out_tdata[4]}))
    else $error("trigger, pulse and report overlap");
`endif

endmodule

>>> tb/ultrasonic_range_speed_zone_tb.sv
// Self-checking testbench for ultrasonic_range_speed_zone: streams microsecond ticks,
// predicts every result tick in-line and compares each field, with APB register writes.
// Depends on ursz_pkg and the ultrasonic_range_speed_zone RTL.
module ultrasonic_range_speed_zone_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ursz_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_PHASES = 5;
  localparam int RAND_TICKS  = 130;

  // One result tick, laid out exactly as out_tdata from bit 0 up
  typedef struct packed {
    logic        busy;
    logic [15:0] speed;
    logic [15:0] distance;
    logic        report;
    logic        buzzer;
    logic        far_led;
    logic        close_led;
    logic        trigger;
  } tick_out_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // from bit 0: read_request, echo_level, zero fill
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // from bit 0: trigger_out, close_led, far_led, buzzer_out, report_valid,
  // distance_out[15:0], speed_out[15:0], busy_res, zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]      cfg_paddr   = '0;
  logic [CFG_DW-1:0]      cfg_pwdata  = '0;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  // Predictor state, reset values
  cfg_t        cfg_shadow = '{cm_divisor: CM_DIVISOR_RST, near_limit_cm: NEAR_LIMIT_RST,
                              mid_limit_cm: MID_LIMIT_RST, far_limit_cm: FAR_LIMIT_RST,
                              settle_ms: SETTLE_MS_RST, near_pulse_ms: NEAR_PULSE_MS_RST,
                              mid_pulse_ms: MID_PULSE_MS_RST, far_pulse_ms: FAR_PULSE_MS_RST};
  phase_t      ph         = PH_IDLE;
  int unsigned ph_timer   = 0;
  logic        echo_last  = 1'b0;
  logic [15:0] echo_ticks = '0;
  logic [15:0] dist_now   = '0;
  logic [15:0] dist_prev  = '0;
  logic [15:0] speed_now  = '0;
  logic [23:0] ms_count   = '0;
  int unsigned us_count   = 0;
  zone_t       zone_sel   = ZONE_NONE;

  tick_out_t   expected_ticks[$];

  int unsigned ticks_sent   = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  int          mismatches   = 0;
  int          reports_seen = 0;
  int          hold_asks    = 0;
  int          hold_served  = 0;
  int          hold_count   = 0;
  int          rx_left      = 0;
  int          cycle_count  = 0;

  ultrasonic_range_speed_zone DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Length in ticks of the phase the sequencer is in
  function automatic int unsigned phase_span();
    case (ph)
      PH_LOW:    return TRIG_LOW_TICKS;
      PH_HIGH:   return TRIG_HIGH_TICKS;
      PH_SETTLE: return cfg_shadow.settle_ms * TICKS_PER_MS;
      PH_PULSE: begin
        if (zone_sel == ZONE_NEAR) return cfg_shadow.near_pulse_ms * TICKS_PER_MS;
        if (zone_sel == ZONE_MID)  return cfg_shadow.mid_pulse_ms * TICKS_PER_MS;
        if (zone_sel == ZONE_FAR)  return cfg_shadow.far_pulse_ms * TICKS_PER_MS;
        return 0;
      end
      PH_REPORT: return REPORT_TICKS;
      default:   return 0;
    endcase
  endfunction

  // Advance the predicted block by one microsecond tick and return its outputs
  function automatic tick_out_t predict_tick(bit req, bit echo);
    tick_out_t   r;
    logic [15:0] moved;
    logic [63:0] rate;
    r = '0;

    // echo width and distance on a falling edge
    if (echo) begin
      if (!echo_last) echo_ticks = 16'd1;
      else if (echo_ticks != 16'hFFFF) echo_ticks++;
    end else if (echo_last && echo_ticks != 0 && cfg_shadow.cm_divisor != 0) begin
      dist_now = echo_ticks / cfg_shadow.cm_divisor;
    end
    echo_last = echo;

    // milliseconds since the last read, saturating
    us_count++;
    if (us_count >= TICKS_PER_MS) begin
      us_count = 0;
      if (ms_count != '1) ms_count++;
    end

    // step through every phase that has run out, zero-length ones included
    while (ph != PH_IDLE && ph_timer >= phase_span()) begin
      if (ph == PH_SETTLE) begin
        if (ms_count != 0) begin
          moved = (dist_now >= dist_prev) ? dist_now - dist_prev : dist_prev - dist_now;
          rate  = 64'(moved) * 64'(SPEED_SCALE) / 64'(ms_count);
          speed_now = (rate > 64'd65535) ? 16'hFFFF : rate[15:0];
        end
        dist_prev = dist_now;
        ms_count  = '0;
        us_count  = 0;
        if (dist_now <= cfg_shadow.near_limit_cm)     zone_sel = ZONE_NEAR;
        else if (dist_now <= cfg_shadow.mid_limit_cm) zone_sel = ZONE_MID;
        else if (dist_now <= cfg_shadow.far_limit_cm) zone_sel = ZONE_FAR;
        else                                          zone_sel = ZONE_NONE;
      end
      ph = (ph == PH_REPORT) ? PH_IDLE : phase_t'(ph + 3'd1);
      ph_timer = 0;
    end

    if (ph == PH_IDLE && req) begin
      ph = PH_LOW;
      ph_timer = 0;
    end
    if (ph != PH_IDLE) begin
      r.busy    = 1'b1;
      r.trigger = (ph == PH_HIGH);
      r.report  = (ph == PH_REPORT);
      if (ph == PH_PULSE) begin
        r.close_led = (zone_sel == ZONE_NEAR) || (zone_sel == ZONE_MID);
        r.buzzer    = (zone_sel == ZONE_NEAR);
        r.far_led   = (zone_sel == ZONE_FAR);
      end
      ph_timer++;
    end
    r.distance = dist_now;
    r.speed    = speed_now;
    return r;
  endfunction

  // Offer one tick, wait for its acceptance, then maybe open a gap
  task automatic send_tick(input bit req, input bit echo);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-2){1'b0}}, echo, req};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    expected_ticks.push_back(predict_tick(req, echo));
    ticks_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Hold the sender until every predicted result has come back
  task automatic await_results();
    in_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Let any running measurement cycle end, then drain
  task automatic finish_cycle();
    while (ph != PH_IDLE) send_tick(1'b0, 1'b0);
    await_results();
  endtask

  task automatic echo_pulse(input int width);
    repeat (width) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // APB write: setup then access; the shadow keeps only the register's width
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CM_DIVISOR:    cfg_shadow.cm_divisor    = value[7:0];
      REG_NEAR_LIMIT:    cfg_shadow.near_limit_cm = value[15:0];
      REG_MID_LIMIT:     cfg_shadow.mid_limit_cm  = value[15:0];
      REG_FAR_LIMIT:     cfg_shadow.far_limit_cm  = value[15:0];
      REG_SETTLE_MS:     cfg_shadow.settle_ms     = value[9:0];
      REG_NEAR_PULSE_MS: cfg_shadow.near_pulse_ms = value[9:0];
      REG_MID_PULSE_MS:  cfg_shadow.mid_pulse_ms  = value[9:0];
      REG_FAR_PULSE_MS:  cfg_shadow.far_pulse_ms  = value[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: ready and stall runs of random length, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_left    <= 0;
    end else if (hold_served != hold_asks) begin
      out_tready <= 1'b0;
      if (hold_count == LONG_HOLD - 1) begin
        hold_served <= hold_served + 1;
        hold_count  <= 0;
      end else begin
        hold_count <= hold_count + 1;
      end
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (out_tready) begin
      case ($urandom_range(0, 3))
        0: rx_left <= $urandom_range(0, 30);
        1: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(0, 2);
        end
        2: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(3, 8);
        end
        default: begin
          out_tready <= 1'b0;
          rx_left    <= $urandom_range(10, 30);
        end
      endcase
    end else begin
      out_tready <= 1'b1;
      rx_left    <= $urandom_range(0, 20);
    end
  end

  // Check each accepted result against the oldest prediction
  always @(negedge clk) begin
    tick_out_t got;
    tick_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(tick_out_t)-1:0];
      if (got.report === 1'b1) reports_seen++;
      if (expected_ticks.size() == 0) begin
        $error("result with no prediction waiting: out_tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("trigger_out", want.trigger, got.trigger);
        check_field("close_led", want.close_led, got.close_led);
        check_field("far_led", want.far_led, got.far_led);
        check_field("buzzer_out", want.buzzer, got.buzzer);
        check_field("report_valid", want.report, got.report);
        check_field("distance_out", want.distance, got.distance);
        check_field("speed_out", want.speed, got.speed);
        check_field("busy_res", want.busy, got.busy);
        check_field("zero fill", '0, out_tdata[OUT_TDATA_W-1:$bits(tick_out_t)]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ultrasonic_range_speed_zone_tb NOT OK");
      $finish;
    end
  end

  // Distance from echo width: single tick, exact quotient, zero divisor, masked divisor
  task automatic test_echo_ranging();
    echo_pulse(1);
    echo_pulse(116);
    await_results();
    write_reg(REG_CM_DIVISOR, 32'd0);
    echo_pulse(50);
    await_results();
    // upper bits dropped, leaving a divisor of one
    write_reg(REG_CM_DIVISOR, 32'hFFFF_FF01);
    echo_pulse(37);
    await_results();
  endtask

  // Trigger sequence, each zone pulse, ignored requests while busy, zero pulse
  task automatic test_read_cycle();
    int widths[3] = '{3, 8, 15};
    write_reg(REG_NEAR_LIMIT, 32'd5);
    write_reg(REG_MID_LIMIT, 32'd10);
    write_reg(REG_FAR_LIMIT, 32'd20);
    write_reg(REG_SETTLE_MS, 32'd0);
    write_reg(REG_NEAR_PULSE_MS, 32'd1);
    write_reg(REG_MID_PULSE_MS, 32'd1);
    write_reg(REG_FAR_PULSE_MS, 32'd1);
    // no zone: straight from settle to report
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0);
    finish_cycle();
    foreach (widths[i]) begin
      echo_pulse(widths[i]);
      send_tick(1'b1, 1'b0);
      finish_cycle();
    end
    write_reg(REG_NEAR_PULSE_MS, 32'd0);
    echo_pulse(4);
    send_tick(1'b1, 1'b0);
    finish_cycle();
  endtask

  // Speed: one millisecond apart, overflow, same millisecond, long gap
  task automatic test_speed();
    write_reg(REG_SETTLE_MS, 32'd1);
    echo_pulse(10);
    send_tick(1'b1, 1'b0);
    finish_cycle();
    echo_pulse(50);
    send_tick(1'b1, 1'b0);
    finish_cycle();
    echo_pulse(250);
    send_tick(1'b1, 1'b0);
    finish_cycle();
    write_reg(REG_SETTLE_MS, 32'd0);
    echo_pulse(240);
    send_tick(1'b1, 1'b0);
    finish_cycle();
    repeat (2500) send_tick(1'b0, 1'b0);
    echo_pulse(100);
    send_tick(1'b1, 1'b0);
    finish_cycle();
  endtask

  // Registers at the top of their range and beyond it
  task automatic test_config_extremes();
    write_reg(REG_CM_DIVISOR, 32'hFFFF_FFFF);
    write_reg(REG_NEAR_LIMIT, 32'h0000_FFFF);
    write_reg(REG_MID_LIMIT, 32'h0000_FFFF);
    write_reg(REG_FAR_LIMIT, 32'h0000_FFFF);
    write_reg(REG_SETTLE_MS, 32'h0000_03FF);
    write_reg(REG_NEAR_PULSE_MS, 32'd1000);
    write_reg(REG_MID_PULSE_MS, 32'd1000);
    write_reg(REG_FAR_PULSE_MS, 32'd1000);
    echo_pulse(600);
    await_results();
    // limits at zero with a nonzero distance: no zone at all
    write_reg(REG_NEAR_LIMIT, 32'd0);
    write_reg(REG_MID_LIMIT, 32'd0);
    write_reg(REG_FAR_LIMIT, 32'd0);
    write_reg(REG_SETTLE_MS, 32'd0);
    send_tick(1'b1, 1'b0);
    finish_cycle();
    // near zone whose pulse length wraps to zero in ten bits
    write_reg(REG_NEAR_LIMIT, 32'h0001_FFFF);
    write_reg(REG_NEAR_PULSE_MS, 32'h0000_0400);
    send_tick(1'b1, 1'b0);
    finish_cycle();
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_stall_fill();
    hold_asks <= hold_asks + 1;
    gaps_on = 1'b0;
    repeat (30) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
    gaps_on = 1'b1;
    finish_cycle();
  endtask

  // Echo held long enough to saturate the width counter
  task automatic test_long_echo();
    write_reg(REG_CM_DIVISOR, 32'd1);
    gaps_on = 1'b0;
    repeat (66000) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    gaps_on = 1'b1;
    await_results();
  endtask

  // Random echo pulses and reads under random settings, with some noise
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned near_cm;
    int unsigned mid_cm;
    int unsigned far_cm;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       write_reg(REG_CM_DIVISOR, 32'd0);
        5:       write_reg(REG_CM_DIVISOR, 32'd255);
        default: write_reg(REG_CM_DIVISOR, $urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        near_cm = $urandom_range(0, 40);
        mid_cm  = $urandom_range(0, 40);
        far_cm  = $urandom_range(0, 40);
      end else begin
        near_cm = $urandom_range(0, 12);
        mid_cm  = near_cm + $urandom_range(0, 10);
        far_cm  = mid_cm + $urandom_range(0, 15);
      end
      write_reg(REG_NEAR_LIMIT, near_cm);
      write_reg(REG_MID_LIMIT, mid_cm);
      write_reg(REG_FAR_LIMIT, far_cm);
      write_reg(REG_SETTLE_MS, ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
      write_reg(REG_NEAR_PULSE_MS, ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);
      write_reg(REG_MID_PULSE_MS, ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);
      write_reg(REG_FAR_PULSE_MS, ($urandom_range(0, 4) == 0) ? 32'd1 : 32'd0);

      start = ticks_sent;
      while (ticks_sent - start < RAND_TICKS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          // echo pulse, a short low stretch, then often a read
          repeat (($urandom_range(0, 7) == 0) ? $urandom_range(41, 300)
                                              : $urandom_range(1, 40))
            send_tick(1'b0, 1'b1);
          repeat ($urandom_range(1, 6)) send_tick(1'b0, 1'b0);
          if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b0);
        end
      end
      finish_cycle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_echo_ranging();
    test_read_cycle();
    test_speed();
    test_config_extremes();
    test_stall_fill();
    test_long_echo();
    test_random_traffic();
    await_results();

    $display("Sent %0d ticks; %0d measurement reports, %0d long receiver hold-offs.",
             ticks_sent, reports_seen, hold_served);
    $display("Covered ranging, trigger and zone pulses, speed limits, long echo, settings.");
    if (mismatches == 0) begin
      $display("ultrasonic_range_speed_zone_tb OK");
    end else begin
      $display("ultrasonic_range_speed_zone_tb NOT OK");
    end
    $finish;
  end

endmodule
